### rtl/core/sdt_pkg.sv
package sdt_pkg;

  // Transport packet geometry.
  localparam int unsigned POS_W          = 8;
  localparam int unsigned LEN_W          = 12;
  localparam int unsigned PKT_LEN        = 188;
  localparam int unsigned START_LOOP_POS = 16;
  localparam int unsigned CONT_LOOP_POS  = 4;
  localparam int unsigned PUSI_BIT       = 6;

  // Section header bytes after section_length, not part of the loop; CRC excluded.
  localparam int unsigned SECT_OVERHEAD  = 8;
  // Smallest remainder of loop bytes (CRC included) in which a new entry may start.
  localparam int unsigned ENTRY_MIN      = 6;
  // Descriptor tag, length and service type bytes ahead of the provider length.
  localparam int unsigned DESC_HDR_LEN   = 3;

  // Kinds of result word.
  localparam logic [2:0] KIND_SERVICE_ID = 3'd0;
  localparam logic [2:0] KIND_PROV_LEN   = 3'd1;
  localparam logic [2:0] KIND_PROV_CHAR  = 3'd2;
  localparam logic [2:0] KIND_SVC_LEN    = 3'd3;
  localparam logic [2:0] KIND_SVC_CHAR   = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_first;
  } sdt_in_t;

  typedef struct packed {
    logic [2:0]  item_kind;
    logic [15:0] item_value;
  } sdt_out_t;

  // What the packet tracker tells the loop parser about the current byte.
  typedef struct packed {
    logic             loop_en;
    logic [LEN_W-1:0] taken;
    logic [LEN_W-1:0] total;
  } loop_ctl_t;

endpackage

### rtl/core/sdt_pkt_track.sv
module sdt_pkt_track (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              consume,
  input  sdt_pkg::sdt_in_t  item,
  output sdt_pkg::loop_ctl_t ctl
);
  import sdt_pkg::*;

  typedef enum logic [2:0] {
    MODE_IGNORE = 3'b001,
    MODE_START  = 3'b010,
    MODE_CONT   = 3'b100
  } pkt_mode_t;

  logic             in_pkt_r, in_pkt_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  pkt_mode_t        mode_r, mode_nxt;
  logic             started_r, started_nxt;
  logic             stopped_r, stopped_nxt;
  logic [3:0]       sect_hi_r, sect_hi_nxt;
  logic [LEN_W-1:0] total_r, total_nxt;
  logic [LEN_W-1:0] taken_r, taken_nxt;

  logic             active;
  logic [POS_W-1:0] pos;
  pkt_mode_t        mode_cur;
  logic             pusi;
  logic             cand;
  logic [LEN_W-1:0] sect_len;

  assign active   = item.packet_first || in_pkt_r;
  assign pos      = item.packet_first ? '0 :
                    (pos_r == {POS_W{1'b1}}) ? pos_r : pos_r + 1'b1;
  assign mode_cur = item.packet_first ? MODE_IGNORE : mode_r;
  assign pusi     = item.data_byte[PUSI_BIT];
  assign sect_len = {sect_hi_r, item.data_byte};

  // Track the position in the packet, the section state and the loop byte count.
  always_comb begin
    in_pkt_nxt  = in_pkt_r;
    pos_nxt     = pos_r;
    mode_nxt    = mode_r;
    started_nxt = started_r;
    stopped_nxt = stopped_r;
    sect_hi_nxt = sect_hi_r;
    total_nxt   = total_r;
    taken_nxt   = taken_r;
    cand        = 1'b0;
    ctl.loop_en = 1'b0;
    ctl.taken   = taken_r;
    ctl.total   = total_r;
    if (consume && active) begin
      in_pkt_nxt = 1'b1;
      pos_nxt    = pos;
      mode_nxt   = mode_cur;
      if (pos == POS_W'(1)) begin
        // Header byte with the payload unit start flag decides the packet's role.
        mode_nxt = MODE_IGNORE;
        if (!stopped_r) begin
          if (pusi && !started_r) begin
            started_nxt = 1'b1;
            mode_nxt    = MODE_START;
          end else if (pusi) begin
            stopped_nxt = 1'b1;
          end else if (started_r) begin
            mode_nxt = MODE_CONT;
          end
        end
      end else if (!stopped_r && mode_cur != MODE_IGNORE && pos < POS_W'(PKT_LEN)) begin
        if (mode_cur == MODE_START) begin
          if (pos == POS_W'(6)) begin
            sect_hi_nxt = item.data_byte[3:0];
          end else if (pos == POS_W'(7)) begin
            total_nxt = (sect_len >= LEN_W'(SECT_OVERHEAD)) ?
                        sect_len - LEN_W'(SECT_OVERHEAD) : '0;
          end else if (pos >= POS_W'(START_LOOP_POS)) begin
            cand = 1'b1;
          end
        end else if (pos >= POS_W'(CONT_LOOP_POS)) begin
          cand = 1'b1;
        end
        if (cand && taken_r < total_r) begin
          ctl.loop_en = 1'b1;
          taken_nxt   = taken_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_pkt_r  <= 1'b0;
      pos_r     <= '0;
      mode_r    <= MODE_IGNORE;
      started_r <= 1'b0;
      stopped_r <= 1'b0;
      sect_hi_r <= '0;
      total_r   <= '0;
      taken_r   <= '0;
    end else begin
      in_pkt_r  <= in_pkt_nxt;
      pos_r     <= pos_nxt;
      mode_r    <= mode_nxt;
      started_r <= started_nxt;
      stopped_r <= stopped_nxt;
      sect_hi_r <= sect_hi_nxt;
      total_r   <= total_nxt;
      taken_r   <= taken_nxt;
    end
  end

endmodule

### rtl/core/sdt_loop_parse.sv
module sdt_loop_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  sdt_pkg::loop_ctl_t  ctl,
  input  logic [7:0]          data_byte,
  output logic                res_valid,
  output sdt_pkg::sdt_out_t   res
);
  import sdt_pkg::*;

  typedef enum logic [10:0] {
    PH_ID_HI     = 11'b000_0000_0001,
    PH_ID_LO     = 11'b000_0000_0010,
    PH_FLAGS     = 11'b000_0000_0100,
    PH_DLEN_HI   = 11'b000_0000_1000,
    PH_DLEN_LO   = 11'b000_0001_0000,
    PH_SKIP_HDR  = 11'b000_0010_0000,
    PH_PROV_LEN  = 11'b000_0100_0000,
    PH_PROV_CHAR = 11'b000_1000_0000,
    PH_SVC_LEN   = 11'b001_0000_0000,
    PH_SVC_CHAR  = 11'b010_0000_0000,
    PH_SKIP_REST = 11'b100_0000_0000
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       field_r, field_nxt;
  logic [LEN_W-1:0] desc_r, desc_nxt;
  logic [7:0]       id_hi_r, id_hi_nxt;
  logic             desc_step;
  logic [LEN_W-1:0] desc_dec;
  logic [LEN_W-1:0] desc_full;
  logic [7:0]       field_dec;
  logic             room;

  assign desc_dec  = desc_r - 1'b1;
  assign desc_full = {desc_r[LEN_W-1:8], data_byte};
  assign field_dec = field_r - 1'b1;
  assign room      = ({1'b0, ctl.taken} + (LEN_W+1)'(ENTRY_MIN)) <= {1'b0, ctl.total};

  // One loop byte moves the entry parser on by one step.
  always_comb begin
    phase_nxt      = phase_r;
    field_nxt      = field_r;
    desc_nxt       = desc_r;
    id_hi_nxt      = id_hi_r;
    desc_step      = 1'b0;
    res_valid      = 1'b0;
    res.item_kind  = KIND_SERVICE_ID;
    res.item_value = {8'h00, data_byte};
    if (ctl.loop_en) begin
      unique case (phase_r)
        PH_ID_HI: begin
          if (room) begin
            id_hi_nxt = data_byte;
            phase_nxt = PH_ID_LO;
          end
        end
        PH_ID_LO: begin
          res_valid      = 1'b1;
          res.item_kind  = KIND_SERVICE_ID;
          res.item_value = {id_hi_r, data_byte};
          phase_nxt      = PH_FLAGS;
        end
        PH_FLAGS: phase_nxt = PH_DLEN_HI;
        PH_DLEN_HI: begin
          desc_nxt  = {data_byte[3:0], 8'h00};
          phase_nxt = PH_DLEN_LO;
        end
        PH_DLEN_LO: begin
          desc_nxt  = desc_full;
          field_nxt = 8'(DESC_HDR_LEN);
          phase_nxt = (desc_full != '0) ? PH_SKIP_HDR : PH_ID_HI;
        end
        PH_SKIP_HDR: begin
          desc_step = 1'b1;
          field_nxt = field_dec;
          if (field_dec == '0) phase_nxt = PH_PROV_LEN;
        end
        PH_PROV_LEN: begin
          desc_step     = 1'b1;
          res_valid     = 1'b1;
          res.item_kind = KIND_PROV_LEN;
          field_nxt     = data_byte;
          phase_nxt     = (data_byte != '0) ? PH_PROV_CHAR : PH_SVC_LEN;
        end
        PH_PROV_CHAR: begin
          desc_step     = 1'b1;
          res_valid     = 1'b1;
          res.item_kind = KIND_PROV_CHAR;
          field_nxt     = field_dec;
          if (field_dec == '0) phase_nxt = PH_SVC_LEN;
        end
        PH_SVC_LEN: begin
          desc_step     = 1'b1;
          res_valid     = 1'b1;
          res.item_kind = KIND_SVC_LEN;
          field_nxt     = data_byte;
          phase_nxt     = (data_byte != '0) ? PH_SVC_CHAR : PH_SKIP_REST;
        end
        PH_SVC_CHAR: begin
          desc_step     = 1'b1;
          res_valid     = 1'b1;
          res.item_kind = KIND_SVC_CHAR;
          field_nxt     = field_dec;
          if (field_dec == '0) phase_nxt = PH_SKIP_REST;
        end
        PH_SKIP_REST: desc_step = 1'b1;
        default: phase_nxt = PH_ID_HI;
      endcase
      // The end of the descriptor loop ends the entry, even inside a name.
      if (desc_step) begin
        desc_nxt = desc_dec;
        if (desc_dec == '0) phase_nxt = PH_ID_HI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ID_HI;
      field_r <= '0;
      desc_r  <= '0;
      id_hi_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      field_r <= field_nxt;
      desc_r  <= desc_nxt;
      id_hi_r <= id_hi_nxt;
    end
  end

  // A result only comes from a loop byte.
  a_res_from_loop: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> ctl.loop_en)
    else $error("result word without a loop byte");

endmodule

### rtl/core/sdt_service_name_parser.sv
// SDT service-name parser.
// The input channel (in_valid, in_stall, in_data) takes one transport stream
// byte per word, with packet_first set on byte 0 of each 188-byte packet.
// The output channel (out_valid, out_stall, out_data) gives one word for each
// service id, provider-name length, provider character, service-name length
// and service character found in the service loop; most bytes give no word.
// A byte is held in the input register and is parsed as it moves into the
// output register, so its word is registered and valid from that register.
// Throughput is one byte per cycle while the receiver does not stall: the
// whole parse step for a byte is a single pass through the packet tracker
// and the entry parser, and the input register takes a new byte in the same
// cycle that the previous one is parsed.
// When the receiver stalls with a word waiting, parsing holds and in_stall
// rises only once the input register is also full.
// The synchronous active-low reset empties both registers and returns the
// parser to waiting for the first payload-start packet.
module sdt_service_name_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sdt_pkg::sdt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sdt_pkg::sdt_out_t out_data
);
  import sdt_pkg::*;

  logic      s1_valid_r;
  sdt_in_t   s1_data_r;
  logic      out_valid_r;
  sdt_out_t  out_data_r;
  logic      advance;
  logic      consume;
  logic      in_take;
  loop_ctl_t ctl;
  logic      res_valid;
  sdt_out_t  res;

  // The stored byte is parsed when the output register is free or being emptied.
  assign advance  = !out_valid_r || !out_stall;
  assign consume  = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  sdt_pkt_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .consume (consume),
    .item    (s1_data_r),
    .ctl     (ctl)
  );

  sdt_loop_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .data_byte (s1_data_r.data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (consume) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= consume && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Input only stalls while a byte is waiting to be parsed.
  a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input register");

  // A parsed byte that yields a word shows it in the next cycle.
  a_word_appears: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && res_valid) |=> out_valid_r)
    else $error("parsed word was lost");

  // Only the five defined kinds ever leave the block.
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.item_kind <= KIND_SVC_CHAR))
    else $error("undefined item kind on output");

endmodule

### tb/sv/sdt_service_name_parser_tb.sv
module sdt_service_name_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdt_pkg::*;

  // Packet geometry as the stream format defines it.
  localparam int PKT_BYTES     = 188;
  localparam int START_LOOP_AT = 16;
  localparam int CONT_LOOP_AT  = 4;
  localparam int LEN_OVERHEAD  = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 8;

  typedef enum logic [3:0] {
    ST_ID_HI, ST_ID_LO, ST_FLAGS, ST_DLEN_HI, ST_DLEN_LO, ST_DESC_HDR,
    ST_PROV_LEN, ST_PROV_CHAR, ST_SVC_LEN, ST_SVC_CHAR, ST_SKIP_REST
  } entry_state_t;

  typedef enum logic [1:0] {PKT_SKIP, PKT_HEAD, PKT_NEXT} pkt_role_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  sdt_in_t   in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  sdt_out_t  out_data;

  sdt_service_name_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state for the section parser.
  logic [7:0]   pkt_pos;
  logic         pkt_active;
  pkt_role_t    pkt_role;
  logic         sect_open;
  logic         sect_closed;
  logic [3:0]   sect_len_hi;
  logic [11:0]  loop_len;
  logic [11:0]  loop_count;
  entry_state_t entry_state;
  logic [11:0]  field_left;
  logic [11:0]  desc_left;
  logic [7:0]   id_hi;

  sdt_out_t    expected_items[$];
  logic [7:0]  loop_fifo[$];
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;
  int          items_sent = 0;
  int          fails = 0;
  int          cycle_count = 0;

  function automatic sdt_out_t make_word(input logic [2:0] kind, input logic [15:0] value);
    sdt_out_t w;
    w.item_kind  = kind;
    w.item_value = value;
    return w;
  endfunction

  // Appends one byte to the loop data still to be sent.
  function automatic void add_loop_byte(input logic [7:0] b);
    loop_fifo.insert(loop_fifo.size(), b);
  endfunction

  // One byte of the service loop moves the entry parser on by one step.
  function automatic bit parse_loop_byte(input logic [7:0] b, output sdt_out_t res);
    logic [11:0] taken;
    bit          hit;
    taken      = loop_count;
    loop_count = loop_count + 12'd1;
    hit        = 1'b0;
    res        = '0;
    case (entry_state)
      ST_ID_HI: begin
        // A new entry only starts while enough loop bytes remain.
        if (taken + 6 <= loop_len) begin
          id_hi       = b;
          entry_state = ST_ID_LO;
        end
        return 1'b0;
      end
      ST_ID_LO: begin
        entry_state = ST_FLAGS;
        res = make_word(KIND_SERVICE_ID, {id_hi, b});
        return 1'b1;
      end
      ST_FLAGS: begin
        entry_state = ST_DLEN_HI;
        return 1'b0;
      end
      ST_DLEN_HI: begin
        desc_left   = {b[3:0], 8'd0};
        entry_state = ST_DLEN_LO;
        return 1'b0;
      end
      ST_DLEN_LO: begin
        desc_left   = desc_left | {4'd0, b};
        field_left  = 12'd3;
        entry_state = (desc_left != 0) ? ST_DESC_HDR : ST_ID_HI;
        return 1'b0;
      end
      ST_DESC_HDR: begin
        field_left = field_left - 12'd1;
        if (field_left == 0) entry_state = ST_PROV_LEN;
      end
      ST_PROV_LEN: begin
        res = make_word(KIND_PROV_LEN, {8'd0, b});
        hit = 1'b1;
        field_left  = {4'd0, b};
        entry_state = (b != 0) ? ST_PROV_CHAR : ST_SVC_LEN;
      end
      ST_PROV_CHAR: begin
        res = make_word(KIND_PROV_CHAR, {8'd0, b});
        hit = 1'b1;
        field_left = field_left - 12'd1;
        if (field_left == 0) entry_state = ST_SVC_LEN;
      end
      ST_SVC_LEN: begin
        res = make_word(KIND_SVC_LEN, {8'd0, b});
        hit = 1'b1;
        field_left  = {4'd0, b};
        entry_state = (b != 0) ? ST_SVC_CHAR : ST_SKIP_REST;
      end
      ST_SVC_CHAR: begin
        res = make_word(KIND_SVC_CHAR, {8'd0, b});
        hit = 1'b1;
        field_left = field_left - 12'd1;
        if (field_left == 0) entry_state = ST_SKIP_REST;
      end
      default: ;
    endcase
    // The end of the descriptor loop ends the entry, even inside a name.
    desc_left = desc_left - 12'd1;
    if (desc_left == 0) entry_state = ST_ID_HI;
    return hit;
  endfunction

  // Packet tracking for one accepted byte; returns 1 when a word is due.
  function automatic bit predict_byte(input sdt_in_t w, output sdt_out_t res);
    logic [7:0]  b;
    logic [11:0] sect_len;
    logic        pusi;
    b   = w.data_byte;
    res = '0;
    if (w.packet_first) begin
      pkt_active = 1'b1;
      pkt_pos    = 8'd0;
      pkt_role   = PKT_SKIP;
    end else if (pkt_active) begin
      if (pkt_pos != 8'd255) pkt_pos = pkt_pos + 8'd1;
    end else begin
      return 1'b0;
    end

    // Byte 1 carries the payload-start flag, which decides the packet's role.
    if (pkt_pos == 8'd1) begin
      pusi     = b[6];
      pkt_role = PKT_SKIP;
      if (!sect_closed) begin
        if (pusi && !sect_open) begin
          sect_open = 1'b1;
          pkt_role  = PKT_HEAD;
        end else if (pusi) begin
          sect_closed = 1'b1;
        end else if (sect_open) begin
          pkt_role = PKT_NEXT;
        end
      end
      return 1'b0;
    end
    if (sect_closed || pkt_role == PKT_SKIP || pkt_pos >= PKT_BYTES) return 1'b0;

    if (pkt_role == PKT_HEAD) begin
      if (pkt_pos == 8'd6) begin
        sect_len_hi = b[3:0];
        return 1'b0;
      end
      if (pkt_pos == 8'd7) begin
        sect_len = {sect_len_hi, b};
        loop_len = (sect_len >= LEN_OVERHEAD) ? sect_len - 12'(LEN_OVERHEAD) : 12'd0;
        return 1'b0;
      end
      if (pkt_pos < START_LOOP_AT) return 1'b0;
    end else if (pkt_pos < CONT_LOOP_AT) begin
      return 1'b0;
    end

    if (loop_count >= loop_len) return 1'b0;
    return parse_loop_byte(b, res);
  endfunction

  // Appends one service entry to the loop data; dl is the descriptor loop length,
  // which may cut the service descriptor short.
  function automatic void push_entry(input logic [15:0] id, input int p_len,
                                     input int s_len, input int extra, input int dl);
    logic [7:0]  desc[$];
    logic [11:0] dl12;
    dl12 = 12'(dl);
    desc.insert(desc.size(), 8'h48);
    desc.insert(desc.size(), 8'(p_len + s_len + 3));
    desc.insert(desc.size(), 8'($urandom));
    desc.insert(desc.size(), 8'(p_len));
    repeat (p_len) desc.insert(desc.size(), 8'($urandom));
    desc.insert(desc.size(), 8'(s_len));
    repeat (s_len) desc.insert(desc.size(), 8'($urandom));
    repeat (extra) desc.insert(desc.size(), 8'($urandom));
    add_loop_byte(id[15:8]);
    add_loop_byte(id[7:0]);
    add_loop_byte(8'($urandom));
    add_loop_byte({4'($urandom), dl12[11:8]});
    add_loop_byte(dl12[7:0]);
    for (int i = 0; i < dl; i++) add_loop_byte(desc[i]);
  endfunction

  // Mostly complete entries with short names; some cut short or empty.
  function automatic void push_random_entry();
    int p_len;
    int s_len;
    int extra;
    int full;
    int sel;
    int dl;
    p_len = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(12);
    s_len = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(12);
    extra = ($urandom_range(3) == 0) ? $urandom_range(8) : 0;
    full  = 5 + p_len + s_len + extra;
    sel   = $urandom_range(9);
    if (sel == 0) dl = 0;
    else if (sel == 1) dl = $urandom_range(full - 1, 1);
    else dl = full;
    push_entry(16'($urandom), p_len, s_len, extra, dl);
  endfunction

  function automatic logic [7:0] next_loop_byte();
    if (loop_fifo.size() == 0) push_random_entry();
    return loop_fifo.pop_front();
  endfunction

  // Offers one word and waits until it is taken, with random idle gaps ahead of it.
  task automatic send_word(input sdt_in_t w);
    sdt_out_t res;
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (predict_byte(w, res)) expected_items.insert(expected_items.size(), res);
  endtask

  // Sends a packet of len bytes; loop_at gives where loop data starts, 0 for none.
  task automatic send_packet(input bit pusi, input int len, input int loop_at);
    sdt_in_t w;
    for (int i = 0; i < len; i++) begin
      w.packet_first = (i == 0);
      if (i == 1) begin
        w.data_byte = {1'($urandom), pusi, 6'($urandom)};
      end else if (loop_at == START_LOOP_AT && i == 6) begin
        // Section length between 0x400 and 0x5ff keeps the loop within the run.
        w.data_byte = {4'($urandom), 3'b010, 1'($urandom)};
      end else if (loop_at != 0 && i >= loop_at && i < PKT_BYTES) begin
        w.data_byte = next_loop_byte();
      end else begin
        w.data_byte = 8'($urandom);
      end
      send_word(w);
    end
  endtask

  // Bytes ahead of the first packet start are ignored.
  task automatic test_bytes_before_sync();
    sdt_in_t w;
    repeat (5) begin
      w.packet_first = 1'b0;
      w.data_byte    = 8'($urandom);
      send_word(w);
    end
  endtask

  // Packets before the first payload start are skipped.
  task automatic test_packets_before_start();
    send_packet(1'b0, 20, 0);
    send_packet(1'b0, 12, CONT_LOOP_AT);
  endtask

  // The start packet carries the section length and the first entries.
  task automatic test_start_packet();
    push_entry(16'hFFFF, 4, 6, 0, 15);
    push_entry(16'h0000, 0, 0, 0, 5);
    push_entry(16'h1234, 3, 3, 0, 0);
    push_entry(16'h8001, 8, 8, 0, 7);
    push_entry(16'h7FFE, 2, 9, 4, 13);
    push_entry(16'hFF00, 1, 1, 6, 13);
    push_entry(16'h00FF, 255, 255, 3, 518);
    send_packet(1'b1, PKT_BYTES, START_LOOP_AT);
  endtask

  // A packet cut short, then one running past its end so the position saturates.
  task automatic test_odd_packet_lengths();
    send_packet(1'b0, 60, CONT_LOOP_AT);
    send_packet(1'b0, 300, CONT_LOOP_AT);
  endtask

  // The receiver holds off for a long stretch while words keep coming.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req++;
    send_packet(1'b0, PKT_BYTES, CONT_LOOP_AT);
  endtask

  // Continuation packets of mostly full length, with some short and long ones.
  task automatic test_random_traffic(input int idle_pct, input int stall_in, input int count);
    int start;
    int sel;
    int len;
    send_idle_pct = idle_pct;
    stall_pct     = stall_in;
    start         = items_sent;
    while (items_sent - start < count) begin
      sel = $urandom_range(99);
      if (sel < 80) len = PKT_BYTES;
      else if (sel < 90) len = $urandom_range(PKT_BYTES - 1, 2);
      else len = $urandom_range(300, PKT_BYTES + 1);
      send_packet(1'b0, len, CONT_LOOP_AT);
    end
  endtask

  // A second payload start stops the parser for good.
  task automatic test_section_stop();
    send_idle_pct = 20;
    stall_pct     = 20;
    send_packet(1'b1, 60, 0);
    send_packet(1'b0, 60, CONT_LOOP_AT);
    send_packet(1'b1, 40, 0);
    send_packet(1'b0, 60, CONT_LOOP_AT);
  endtask

  // Receiver stall pattern, with the long hold-off counted down here.
  always @(negedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
    end
  end

  // Each word taken is compared with the oldest prediction.
  always @(posedge clk) begin
    sdt_out_t exp_word;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_items.size() == 0) begin
        $error("unexpected word: item_kind %0d, item_value %0h",
               out_data.item_kind, out_data.item_value);
        fails++;
      end else begin
        exp_word = expected_items.pop_front();
        if (out_data.item_kind !== exp_word.item_kind) begin
          $error("item_kind: expected %0d, actual %0d", exp_word.item_kind, out_data.item_kind);
          fails++;
        end
        if (out_data.item_value !== exp_word.item_value) begin
          $error("item_value: expected %0h, actual %0h",
                 exp_word.item_value, out_data.item_value);
          fails++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sdt_service_name_parser test failed");
      $finish;
    end
  end

  initial begin
    pkt_pos     = '0;
    pkt_active  = 1'b0;
    pkt_role    = PKT_SKIP;
    sect_open   = 1'b0;
    sect_closed = 1'b0;
    sect_len_hi = '0;
    loop_len    = '0;
    loop_count  = '0;
    entry_state = ST_ID_HI;
    field_left  = '0;
    desc_left   = '0;
    id_hi       = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_bytes_before_sync();
    test_packets_before_start();
    test_start_packet();
    test_odd_packet_lengths();
    test_output_backpressure();
    test_random_traffic(0, 0, 100);
    test_random_traffic(70, 0, 100);
    test_random_traffic(0, 70, 100);
    test_random_traffic(37, 37, 100);
    test_section_stop();

    // Drain what is still in flight.
    @(negedge clk);
    in_valid  = 1'b0;
    stall_pct = 0;
    while (expected_items.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fails == 0) begin
      $display("sdt_service_name_parser test passed");
    end else begin
      $display("sdt_service_name_parser test failed");
    end
    $finish;
  end

endmodule
